### src/hnorm_pkg.sv
package hnorm_pkg;

   // Fixed-point scale: ONE = 2**FRAC_BITS stands for 1.0
   localparam int FRAC_BITS_DEF = 14;
   localparam int FRAC_BITS_MAX = 30;

   // Width of the raw field and the configured range
   localparam int RAW_W  = 32;
   // Width of the output axis value
   localparam int AXIS_W = 16;
   // Width that holds any intermediate result before saturation
   localparam int SAT_W  = FRAC_BITS_MAX + 4;

   localparam logic signed [SAT_W-1:0] AXIS_MAX = SAT_W'(32767);
   localparam logic signed [SAT_W-1:0] AXIS_MIN = -SAT_W'(32768);

   // Register indexes of the configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_BITS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_MODE  = 2'd3;

   // Axis modes
   localparam logic [1:0] MODE_SIGNED  = 2'd0;
   localparam logic [1:0] MODE_NEGATED = 2'd1;
   localparam logic [1:0] MODE_TRIGGER = 2'd2;

   // Reset values of the configuration registers
   localparam logic [RAW_W-1:0] RANGE_MIN_RST  = 32'd0;
   localparam logic [RAW_W-1:0] RANGE_MAX_RST  = 32'd255;
   localparam logic [5:0]       FIELD_BITS_RST = 6'd8;
   localparam logic [1:0]       AXIS_MODE_RST  = MODE_SIGNED;

   // Where the sample sits relative to the declared range
   typedef enum logic [1:0] {
      RC_INSIDE,
      RC_BELOW,
      RC_ABOVE,
      RC_DEGEN
   } range_class_type;

endpackage

### src/hid_axis_normalizer.sv
// Channel    Direction  Handshake            Payload
// req        in         req_valid/req_stall  req_raw_value[31:0]
// rsp        out        rsp_valid/rsp_stall  rsp_axis_value[15:0], rsp_degenerate_range
// csr        in         csr_write_en         csr_index[1:0], csr_wdata[31:0]
//
// One transaction per cycle sustained unless rsp stalls; the stages are one classify
// stage, FRAC_BITS + 1 divider cells (one quotient bit each), one output stage.
// Synchronous reset restores the register defaults and empties every stage.
// A stall on rsp freezes only stages that are full; empty stages keep filling.
module hid_axis_normalizer import hnorm_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RAW_W-1:0]         req_raw_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [AXIS_W-1:0] rsp_axis_value,
   output logic                     rsp_degenerate_range,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [RAW_W-1:0]         csr_wdata
);

   localparam int QW = FRAC_BITS + 1;

   logic [RAW_W-1:0]  range_min_ff;
   logic [RAW_W-1:0]  range_max_ff;
   logic [5:0]        field_bits_ff;
   logic [1:0]        axis_mode_ff;
   logic [RAW_W-1:0]  span;

   logic              valid_w [QW+1];
   logic              hold_w  [QW+1];
   logic [RAW_W-1:0]  rem_w   [QW+1];
   logic [QW-1:0]     quo_w   [QW+1];
   range_class_type   cls_w   [QW+1];

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff  <= RANGE_MIN_RST;
         range_max_ff  <= RANGE_MAX_RST;
         field_bits_ff <= FIELD_BITS_RST;
         axis_mode_ff  <= AXIS_MODE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RANGE_MIN:  range_min_ff  <= csr_wdata;
            CSR_RANGE_MAX:  range_max_ff  <= csr_wdata;
            CSR_FIELD_BITS: field_bits_ff <= csr_wdata[5:0];
            CSR_AXIS_MODE:  axis_mode_ff  <= csr_wdata[1:0];
            default:        ;
         endcase
      end
   end

   // Span is exact in 32 bits whenever the range is not degenerate
   assign span = range_max_ff - range_min_ff;

   hnorm_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_hold    (req_stall),
      .raw_value  (req_raw_value),
      .range_min  (range_min_ff),
      .range_max  (range_max_ff),
      .field_bits (field_bits_ff),
      .out_valid  (valid_w[0]),
      .out_hold   (hold_w[0]),
      .out_rem    (rem_w[0]),
      .out_cls    (cls_w[0])
   );

   assign quo_w[0] = '0;

   // Row of divider cells, one quotient bit per cell
   for (genvar i = 0; i < QW; i++) begin : g_cell
      hnorm_div_cell #(
         .QW (QW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_hold   (hold_w[i]),
         .in_rem    (rem_w[i]),
         .in_quo    (quo_w[i]),
         .in_cls    (cls_w[i]),
         .span      (span),
         .out_valid (valid_w[i+1]),
         .out_hold  (hold_w[i+1]),
         .out_rem   (rem_w[i+1]),
         .out_quo   (quo_w[i+1]),
         .out_cls   (cls_w[i+1])
      );
   end

   hnorm_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (valid_w[QW]),
      .in_hold              (hold_w[QW]),
      .in_quo               (quo_w[QW]),
      .in_cls               (cls_w[QW]),
      .axis_mode            (axis_mode_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_axis_value       (rsp_axis_value),
      .rsp_degenerate_range (rsp_degenerate_range)
   );

   // A draining output frees the whole row
   a_drain_frees_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |-> !req_stall)
      else $error("input stalled while output drains");

   // Stalling the input requires a full classify stage
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_w[0])
      else $error("input stalled with empty front stage");

   // Degenerate range on a signed axis reports zero
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate_range && axis_mode_ff == MODE_SIGNED)
         |-> (rsp_axis_value == '0))
      else $error("degenerate range gave nonzero axis value");

   // Trigger mode never reports a negative value
   a_trigger_nonneg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && axis_mode_ff == MODE_TRIGGER) |-> !rsp_axis_value[AXIS_W-1])
      else $error("trigger mode gave negative value");

endmodule

### src/hnorm_prep.sv
module hnorm_prep import hnorm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_hold,
   input  logic [RAW_W-1:0]        raw_value,
   input  logic [RAW_W-1:0]        range_min,
   input  logic [RAW_W-1:0]        range_max,
   input  logic [5:0]              field_bits,
   output logic                    out_valid,
   input  logic                    out_hold,
   output logic [RAW_W-1:0]        out_rem,
   output range_class_type         out_cls
);

   logic                 valid_ff;
   logic [RAW_W-1:0]     rem_ff;
   logic [RAW_W-1:0]     rem_in;
   range_class_type      cls_ff;
   range_class_type      cls_in;
   logic                 do_ext;
   logic                 field_msb;
   logic [RAW_W-1:0]     ext_mask;
   logic [RAW_W-1:0]     value;
   logic                 load;

   // Sign-extend the raw field from its declared width when the range minimum is negative
   always_comb begin
      do_ext    = range_min[RAW_W-1] && (field_bits != 6'd0) && (field_bits < 6'd32);
      field_msb = raw_value[field_bits[4:0] - 5'd1];
      ext_mask  = {RAW_W{1'b1}} << field_bits;
      value     = (do_ext && field_msb) ? (raw_value | ext_mask) : raw_value;
   end

   // Classify against the range and form the offset from the minimum
   always_comb begin
      rem_in = value - range_min;
      if ($signed(range_max) <= $signed(range_min)) begin
         cls_in = RC_DEGEN;
      end else if ($signed(value) <= $signed(range_min)) begin
         cls_in = RC_BELOW;
      end else if ($signed(value) >= $signed(range_max)) begin
         cls_in = RC_ABOVE;
      end else begin
         cls_in = RC_INSIDE;
      end
   end

   // Hold only when full and blocked downstream
   assign in_hold = valid_ff & out_hold;
   assign load    = !in_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         rem_ff <= rem_in;
         cls_ff <= cls_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_cls   = cls_ff;

endmodule

### src/hnorm_div_cell.sv
module hnorm_div_cell import hnorm_pkg::*; #(
   parameter int QW = FRAC_BITS_DEF + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_hold,
   input  logic [RAW_W-1:0]        in_rem,
   input  logic [QW-1:0]           in_quo,
   input  range_class_type         in_cls,
   input  logic [RAW_W-1:0]        span,
   output logic                    out_valid,
   input  logic                    out_hold,
   output logic [RAW_W-1:0]        out_rem,
   output logic [QW-1:0]           out_quo,
   output range_class_type         out_cls
);

   logic                 valid_ff;
   logic [RAW_W-1:0]     rem_ff;
   logic [RAW_W-1:0]     rem_in;
   logic [QW-1:0]        quo_ff;
   logic [QW-1:0]        quo_in;
   range_class_type      cls_ff;
   logic [RAW_W:0]       shifted;
   logic [RAW_W:0]       diff;
   logic                 take;
   logic                 load;

   // One restoring division step: shift, compare, subtract
   always_comb begin
      shifted = {in_rem, 1'b0};
      diff    = shifted - {1'b0, span};
      take    = (shifted >= {1'b0, span});
      rem_in  = take ? diff[RAW_W-1:0] : shifted[RAW_W-1:0];
      quo_in  = {in_quo[QW-2:0], take};
   end

   assign in_hold = valid_ff & out_hold;
   assign load    = !in_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cls_ff <= in_cls;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_cls   = cls_ff;

endmodule

### src/hnorm_out.sv
module hnorm_out import hnorm_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_hold,
   input  logic [FRAC_BITS:0]       in_quo,
   input  range_class_type          in_cls,
   input  logic [1:0]               axis_mode,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [AXIS_W-1:0] rsp_axis_value,
   output logic                     rsp_degenerate_range
);

   localparam int RW = FRAC_BITS + 3;
   localparam logic signed [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;

   logic                     valid_ff;
   logic signed [AXIS_W-1:0] axis_ff;
   logic signed [AXIS_W-1:0] axis_in;
   logic                     degen_ff;
   logic signed [RW-1:0]     r;
   logic signed [RW-1:0]     res;
   logic signed [SAT_W-1:0]  res_wide;
   logic                     load;

   // Map the quotient onto [-ONE, ONE]
   always_comb begin
      case (in_cls)
         RC_DEGEN:  r = '0;
         RC_BELOW:  r = -ONE_R;
         RC_ABOVE:  r = ONE_R;
         RC_INSIDE: r = $signed({2'b00, in_quo}) - ONE_R;
         default:   r = '0;
      endcase
   end

   // Apply the axis mode
   always_comb begin
      case (axis_mode)
         MODE_NEGATED: res = -r;
         MODE_TRIGGER: res = (r + ONE_R) >>> 1;
         default:      res = r;
      endcase
   end

   // Saturate to the 16-bit output
   always_comb begin
      res_wide = {{(SAT_W-RW){res[RW-1]}}, res};
      if (res_wide > AXIS_MAX) begin
         axis_in = AXIS_MAX[AXIS_W-1:0];
      end else if (res_wide < AXIS_MIN) begin
         axis_in = AXIS_MIN[AXIS_W-1:0];
      end else begin
         axis_in = res_wide[AXIS_W-1:0];
      end
   end

   assign in_hold = valid_ff & rsp_stall;
   assign load    = !in_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         axis_ff  <= axis_in;
         degen_ff <= (in_cls == RC_DEGEN);
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_axis_value       = axis_ff;
   assign rsp_degenerate_range = degen_ff;

endmodule
